FILE: rtl/crmm_pkg.sv
`timescale 1ns / 1ps

package crmm_pkg;

  // Width and reset value of the window length register.
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 7'd3;

  // Job kinds passed from the front end to the scan engine.
  typedef enum logic {
    OP_WRITE,
    OP_SCAN
  } crmm_op_t;

endpackage

FILE: rtl/crmm_queue.sv
`timescale 1ns / 1ps

module crmm_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue: pop while empty");

endmodule

FILE: rtl/crmm_front.sv
`timescale 1ns / 1ps

module crmm_front import crmm_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int JOB_W       = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_missing,
  input  logic                          end_of_series,
  output logic                          q_push,
  output logic [JOB_W-1:0]              q_push_data,
  input  logic                          q_full
);

  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  typedef struct packed {
    crmm_op_t                      op;
    logic [SLOT_W-1:0]             slot;
    logic [CNT_W-1:0]              len;
    logic                          last;
    logic                          missing;
    logic signed [SAMPLE_BITS-1:0] value;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_SCAN
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  window_length;
  logic [CNT_W-1:0]  samples_seen;
  logic [SLOT_W-1:0] write_slot;
  // per-item context
  logic [SLOT_W-1:0] newest;
  logic [CNT_W-1:0]  seen;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  half;
  logic              eos;
  logic [CNT_W-1:0]  t;

  logic              accept;
  logic [CNT_W-1:0]  span_eff;
  logic [CNT_W-1:0]  seen_next;
  logic [SLOT_W-1:0] slot_next;
  logic [CNT_W:0]    reach;
  logic [CNT_W-1:0]  span_left;
  logic [CNT_W-1:0]  scan_len;
  logic              emit;
  logic              final_step;
  job_t              job;

  assign in_ready = (state == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // length 0 acts as 1, anything above the store depth as the depth
  always_comb begin
    if (window_length == '0) begin
      span_eff = CNT_W'(1);
    end else if (int'(window_length) > WINDOW_MAX) begin
      span_eff = CNT_W'(WINDOW_MAX);
    end else begin
      span_eff = CNT_W'(window_length);
    end
  end

  assign seen_next = (samples_seen < CNT_W'(WINDOW_MAX)) ? samples_seen + 1'b1 : samples_seen;
  assign slot_next = (write_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : write_slot + 1'b1;

  // step t covers position lag t; t = 0 is the regular result
  assign reach      = {1'b0, seen} + {1'b0, t};
  assign emit       = reach > {1'b0, half};
  assign span_left  = span - t;
  assign scan_len   = (span_left < seen) ? span_left : seen;
  assign final_step = !eos || (t == half);

  always_comb begin
    job = '0;
    if (state == F_IDLE) begin
      job.op      = OP_WRITE;
      job.slot    = write_slot;
      job.missing = sample_missing;
      job.value   = sample;
    end else begin
      job.op   = OP_SCAN;
      job.slot = newest;
      job.len  = scan_len;
      job.last = eos && (t == half);
    end
  end

  assign q_push      = accept || ((state == F_SCAN) && emit && !q_full);
  assign q_push_data = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      window_length <= WINDOW_LENGTH_RESET;
      samples_seen  <= '0;
      write_slot    <= '0;
    end else begin
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      case (state)
        F_IDLE: begin
          if (accept) begin
            newest       <= write_slot;
            seen         <= seen_next;
            span         <= span_eff;
            half         <= span_eff >> 1;
            eos          <= end_of_series;
            t            <= '0;
            samples_seen <= end_of_series ? '0 : seen_next;
            write_slot   <= end_of_series ? '0 : slot_next;
            state        <= F_SCAN;
          end
        end
        F_SCAN: begin
          if (!emit || !q_full) begin
            if (final_step) begin
              state <= F_IDLE;
            end else begin
              t <= t + 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    (state == F_SCAN) |-> (t <= half))
    else $error("front: tail step beyond half window");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == F_SCAN && emit) |-> (scan_len != '0))
    else $error("front: empty scan queued");

endmodule

FILE: rtl/crmm_back.sv
`timescale 1ns / 1ps

module crmm_back import crmm_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int JOB_W       = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [JOB_W-1:0]              q_pop_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] min_value,
  output logic                          min_missing,
  output logic signed [SAMPLE_BITS-1:0] max_value,
  output logic                          max_missing,
  output logic                          last_of_series
);

  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  typedef struct packed {
    crmm_op_t                      op;
    logic [SLOT_W-1:0]             slot;
    logic [CNT_W-1:0]              len;
    logic                          last;
    logic                          missing;
    logic signed [SAMPLE_BITS-1:0] value;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_WAIT,
    B_DONE
  } state_t;

  job_t                          job;
  state_t                        state;
  logic [SAMPLE_BITS:0]          store [WINDOW_MAX];
  logic [SAMPLE_BITS:0]          rd_data;
  logic                          rd_valid;
  logic [SLOT_W-1:0]             rd_idx;
  logic [CNT_W-1:0]              remaining;
  logic                          scan_last;
  logic                          acc_any;
  logic signed [SAMPLE_BITS-1:0] acc_lo;
  logic signed [SAMPLE_BITS-1:0] acc_hi;
  logic signed [SAMPLE_BITS-1:0] rd_sample;
  logic                          rd_absent;

  assign job       = q_pop_data;
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign rd_sample = rd_data[SAMPLE_BITS-1:0];
  assign rd_absent = rd_data[SAMPLE_BITS];

  // sample store: bit SAMPLE_BITS marks a missing sample
  always_ff @(posedge clk) begin
    if (q_pop && job.op == OP_WRITE) begin
      store[job.slot] <= {job.missing, job.value};
    end
    rd_data <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= (state == B_READ);
      // a result loaded in B_DONE takes over the register in the same edge
      if (out_valid && out_ready && state != B_DONE) begin
        out_valid <= 1'b0;
      end
      if (rd_valid && !rd_absent) begin
        if (!acc_any || rd_sample < acc_lo) acc_lo <= rd_sample;
        if (!acc_any || rd_sample > acc_hi) acc_hi <= rd_sample;
        acc_any <= 1'b1;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty && job.op == OP_SCAN) begin
            rd_idx    <= job.slot;
            remaining <= job.len;
            scan_last <= job.last;
            acc_any   <= 1'b0;
            state     <= B_READ;
          end
        end
        B_READ: begin
          // walk backwards from the newest entry
          rd_idx    <= (rd_idx == '0) ? SLOT_W'(WINDOW_MAX - 1) : rd_idx - 1'b1;
          remaining <= remaining - 1'b1;
          if (remaining == CNT_W'(1)) begin
            state <= B_WAIT;
          end
        end
        B_WAIT: state <= B_DONE;
        B_DONE: begin
          if (!out_valid || out_ready) begin
            min_value      <= acc_any ? acc_lo : '0;
            max_value      <= acc_any ? acc_hi : '0;
            min_missing    <= !acc_any;
            max_missing    <= !acc_any;
            last_of_series <= scan_last;
            out_valid      <= 1'b1;
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_READ) |-> (remaining != '0))
    else $error("back: scan with no entries left");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE) |-> !rd_valid)
    else $error("back: read data still in flight at result");

endmodule

FILE: rtl/centered_running_min_max_core.sv
`timescale 1ns / 1ps

// Channel  Handshake                Word
// -------  -----------------------  ----------------------------------------------
// in       in_valid / in_ready      sample, sample_missing, end_of_series
// out      out_valid / out_ready    min_value, min_missing, max_value, max_missing,
//                                   last_of_series
// cfg      cfg_wr_en (no wait)      cfg_wr_data = window length
//
// Flow: the front end takes a word and queues a store write plus one scan job per
// result, one job a cycle while the job queue is not full. The scan engine reads the
// k entries of a scan one by one through the single read port of the sample store;
// the front end can take a new word while the scan engine still works on earlier
// jobs.
// Reset: synchronous, clears control only; the sample store holds old data and is
// only ever read at entries written in the current series. No clearing pass.
// Stalls: a full job queue stalls input; a held result stalls the scan engine, and the input once the queue fills.

module centered_running_min_max_core import crmm_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_missing,
  input  logic                          end_of_series,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] min_value,
  output logic                          min_missing,
  output logic signed [SAMPLE_BITS-1:0] max_value,
  output logic                          max_missing,
  output logic                          last_of_series
);

  localparam int SLOT_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  // job word: op, slot, length, last flag, missing flag, sample
  localparam int JOB_W       = 1 + SLOT_W + CNT_W + 1 + 1 + SAMPLE_BITS;
  localparam int QUEUE_DEPTH = 4;

  logic             q_push;
  logic [JOB_W-1:0] q_push_data;
  logic             q_full;
  logic             q_pop;
  logic [JOB_W-1:0] q_pop_data;
  logic             q_empty;

  // Front end: config register, series counters, splits each word into jobs.
  crmm_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .sample_missing (sample_missing),
    .end_of_series  (end_of_series),
    .q_push         (q_push),
    .q_push_data    (q_push_data),
    .q_full         (q_full)
  );

  // Jobs are kept in order, so a store write always lands before the scans that
  // need it and after the scans that read the slot's older contents.
  crmm_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Scan engine: owns the sample store, folds min/max, holds the output register.
  crmm_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_pop_data     (q_pop_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .min_value      (min_value),
    .min_missing    (min_missing),
    .max_value      (max_value),
    .max_missing    (max_missing),
    .last_of_series (last_of_series)
  );

endmodule
